/* src/pen_pkg.sv */
// ----------------------------------------------------------------------------
// pen_pkg: shared types and constants for the polygon edge normal builder
// Beat payload structs, opcode set of the shared datapath unit, sizes.
// ----------------------------------------------------------------------------
package pen_pkg;

    localparam int UNIT_ONE = 16384;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic               face_end;
    } pen_in_t;

    typedef struct packed {
        logic [3:0]         edge_index;
        logic signed [15:0] edge_nx;
        logic signed [15:0] edge_ny;
        logic signed [15:0] edge_nz;
        logic               flipped;
        logic signed [15:0] plane_nx;
        logic signed [15:0] plane_ny;
        logic signed [15:0] plane_nz;
        logic signed [31:0] centroid_x;
        logic signed [31:0] centroid_y;
        logic signed [31:0] centroid_z;
        logic               last_edge;
    } pen_out_t;

    // iterative unit commands
    typedef enum logic [1:0] {
        DIV_SIGNED = 2'd0,
        SQRT_U     = 2'd1
    } pen_op_t;

    typedef struct packed {
        logic    start;
        pen_op_t op;
    } pen_unit_ctl_t;

endpackage

/* src/pen_divsqrt.sv */
// ----------------------------------------------------------------------------
// pen_divsqrt: shared bit-serial divider / integer square root
// Restoring division (signed, truncating) or digit-by-digit square root,
// one quotient bit or one root bit per cycle.
// ----------------------------------------------------------------------------
module pen_divsqrt
    import pen_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pen_unit_ctl_t        ctl,
    input  logic signed [79:0]   num,
    input  logic        [63:0]   den,
    output logic                 done,
    output logic signed [79:0]   result
);

    logic [79:0] rem_reg, rem_next;
    logic [79:0] quo_reg, quo_next;
    logic [79:0] src_reg, src_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    pen_op_t     op_reg, op_next;
    logic        done_reg, done_next;
    logic [79:0] trial;
    logic [79:0] shifted;
    logic [79:0] num_mag;

    assign num_mag = num[79] ? 80'(-num) : 80'(num);

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        src_next  = src_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        trial     = '0;
        shifted   = '0;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            rem_next  = '0;
            quo_next  = '0;
            den_next  = den;
            if (ctl.op == DIV_SIGNED)
            begin
                src_next = num_mag;
                neg_next = num[79];
                cnt_next = 7'd80;
            end
            else
            begin
                src_next = {16'd0, num[63:0]};
                neg_next = 1'b0;
                cnt_next = 7'd32;
            end
        end
        else if (busy_reg)
        begin
            case (op_reg)
                DIV_SIGNED:
                begin
                    shifted  = {rem_reg[78:0], src_reg[79]};
                    src_next = {src_reg[78:0], 1'b0};
                    trial    = shifted - {16'd0, den_reg};
                    if (shifted >= {16'd0, den_reg})
                    begin
                        rem_next = trial;
                        quo_next = {quo_reg[78:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = shifted;
                        quo_next = {quo_reg[78:0], 1'b0};
                    end
                end
                SQRT_U:
                begin
                    // two radicand bits in, one root bit out
                    shifted  = {rem_reg[77:0], src_reg[63:62]};
                    src_next = {src_reg[79:64], src_reg[61:0], 2'b00};
                    trial    = {quo_reg[77:0], 2'b01};
                    if (shifted >= trial)
                    begin
                        rem_next = shifted - trial;
                        quo_next = {quo_reg[78:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = shifted;
                        quo_next = {quo_reg[78:0], 1'b0};
                    end
                end
                default:
                begin
                    rem_next = rem_reg;
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        src_reg <= src_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        op_reg  <= op_next;
    end

    assign done   = done_reg;
    assign result = neg_reg ? 80'(-quo_reg) : 80'(quo_reg);

endmodule

/* src/polygon_edge_normal_builder_core.sv */
// ----------------------------------------------------------------------------
// polygon_edge_normal_builder_core: per-face centroid, plane and edge normals
//
// Input channel (in_valid/in_ready, pen_in_t): one vertex per beat, face_end
// on the last one. On the closing beat of a face of three or more vertices
// the block goes busy (in_ready low) and runs a sequencer over one shared
// bit-serial divide/sqrt unit and one 33x33 multiplier: three centroid
// divides, plane normal sqrt and three divides, then per edge a cross
// product, one sqrt, three divides and a dot product. Output channel
// (out_valid/out_ready, pen_out_t): one beat per edge, in edge order,
// last_edge on the final one. A stalled receiver holds the sequencer;
// nothing is lost. Faces with fewer than three vertices give no beats.
// Vertices beyond MAX_VERTICES are dropped.
// Reset clears the count, sums and sequencer; the vertex store is not
// cleared (only written entries are read).
// ----------------------------------------------------------------------------
module polygon_edge_normal_builder_core
    import pen_pkg::*;
#(
    parameter int MAX_VERTICES = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pen_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pen_out_t out_data
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_CDIV  = 11'b00000000010,
        S_PLANE = 11'b00000000100,
        S_PSQRT = 11'b00000001000,
        S_PDIV  = 11'b00000010000,
        S_EPREP = 11'b00000100000,
        S_ECRS  = 11'b00001000000,
        S_ESQRT = 11'b00010000000,
        S_EDIV  = 11'b00100000000,
        S_EDOT  = 11'b01000000000,
        S_EOUT  = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic signed [31:0] vx_mem [MAX_VERTICES];
    logic signed [31:0] vy_mem [MAX_VERTICES];
    logic signed [31:0] vz_mem [MAX_VERTICES];

    logic [CW-1:0]      count_reg;
    logic signed [35+IW:0] sum_reg [3];
    logic [IW-1:0]      idx_reg;
    logic [1:0]         k_reg;
    logic [2:0]         sub_reg;
    logic               started_reg;
    logic               pn_valid_reg;

    logic signed [31:0] cen_reg [3];
    logic signed [63:0] vec_reg [3];
    logic signed [31:0] red_reg [3];
    logic signed [15:0] pn_reg [3];
    logic signed [15:0] un_reg [3];
    logic [63:0]        acc_reg;
    logic [31:0]        len_reg;
    logic signed [79:0] dot_reg;
    logic signed [32:0] ea_reg [3];
    logic signed [32:0] eb_reg [3];
    logic signed [31:0] vi_reg [3];
    logic               out_valid_reg;
    pen_out_t           out_reg;

    pen_unit_ctl_t      uctl;
    logic signed [79:0] unum;
    logic [63:0]        uden;
    logic               udone;
    logic signed [79:0] ures;

    pen_divsqrt u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (uctl),
        .num   (unum),
        .den   (uden),
        .done  (udone),
        .result(ures)
    );

    logic in_fire;
    assign in_ready = (state_reg == S_LOAD);
    assign in_fire  = in_valid && in_ready;

    // reduction of a 64-bit signed triple below 2^30 by common right shift
    function automatic logic [5:0] red_shift(input logic signed [63:0] a,
                                             input logic signed [63:0] b,
                                             input logic signed [63:0] c);
        logic [63:0] m;
        logic [5:0]  s;
        m = (a[63] ? 64'(-a) : 64'(a)) | (b[63] ? 64'(-b) : 64'(b))
          | (c[63] ? 64'(-c) : 64'(c));
        s = '0;
        for (int i = 30; i < 64; i++)
        begin
            if (m[i])
            begin
                s = 6'(i - 29);
            end
        end
        return s;
    endfunction

    function automatic logic signed [31:0] shr_mag(input logic signed [63:0] v,
                                                   input logic [5:0] s);
        logic [63:0] m;
        m = (v[63] ? 64'(-v) : 64'(v)) >> s;
        return v[63] ? 32'(-m) : 32'(m);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // any component of an edge at or above 2^31 in magnitude
    function automatic logic over31(input logic signed [32:0] a,
                                    input logic signed [32:0] b,
                                    input logic signed [32:0] c);
        logic [32:0] m;
        m = mag33(a) | mag33(b) | mag33(c);
        return m[32] | m[31];
    endfunction

    function automatic logic signed [32:0] halve33(input logic signed [32:0] v,
                                                   input logic s);
        logic [32:0] m;
        m = mag33(v);
        if (s)
            m = m >> 1;
        return v[32] ? 33'(-m) : 33'(m);
    endfunction

    // cyclic component neighbors for the cross product
    function automatic logic [1:0] idx_p1(input logic [1:0] k);
        case (k)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] idx_p2(input logic [1:0] k);
        case (k)
            2'd0:    return 2'd2;
            2'd1:    return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    // single shared multiplier, 33x33
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [5:0] rsh;
    assign rsh = red_shift(vec_reg[0], vec_reg[1], vec_reg[2]);

    logic ea_big, eb_big;
    assign ea_big = over31(ea_reg[0], ea_reg[1], ea_reg[2]);
    assign eb_big = over31(eb_reg[0], eb_reg[1], eb_reg[2]);

    always_comb
    begin
        uctl.start = 1'b0;
        uctl.op    = DIV_SIGNED;
        unum       = '0;
        uden       = '0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            S_CDIV:
            begin
                unum = 80'(sum_reg[k_reg]);
                uden = 64'(count_reg);
                uctl.start = !started_reg;
            end
            S_PSQRT, S_ESQRT:
            begin
                uctl.op = SQRT_U;
                unum = {16'd0, acc_reg};
                uctl.start = !started_reg && (sub_reg == 3'd4);
                mul_a = 33'(red_reg[k_reg]);
                mul_b = 33'(red_reg[k_reg]);
            end
            S_PDIV, S_EDIV:
            begin
                unum = 80'(red_reg[k_reg]) <<< 14;
                uden = 64'(len_reg);
                uctl.start = !started_reg && (len_reg != 0);
            end
            S_PLANE:
            begin
                mul_a = sub_reg[0] ? ea_reg[idx_p2(k_reg)] : ea_reg[idx_p1(k_reg)];
                mul_b = sub_reg[0] ? eb_reg[idx_p1(k_reg)] : eb_reg[idx_p2(k_reg)];
            end
            S_ECRS:
            begin
                mul_a = sub_reg[0] ? 33'(pn_reg[idx_p2(k_reg)])
                                   : 33'(pn_reg[idx_p1(k_reg)]);
                mul_b = sub_reg[0] ? ea_reg[idx_p1(k_reg)]
                                   : ea_reg[idx_p2(k_reg)];
            end
            S_EDOT:
            begin
                mul_a = 33'(un_reg[k_reg]);
                mul_b = 33'(cen_reg[k_reg]) - 33'(vi_reg[k_reg]);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && count_reg < CW'(MAX_VERTICES))
        begin
            vx_mem[count_reg[IW-1:0]] <= in_data.vertex_x;
            vy_mem[count_reg[IW-1:0]] <= in_data.vertex_y;
            vz_mem[count_reg[IW-1:0]] <= in_data.vertex_z;
        end
    end

    logic [IW-1:0] rd_addr;
    logic signed [31:0] rdx, rdy, rdz;
    always_ff @(posedge clk)
    begin
        rdx <= vx_mem[rd_addr];
        rdy <= vy_mem[rd_addr];
        rdz <= vz_mem[rd_addr];
    end

    logic [IW-1:0] nxt_idx;
    assign nxt_idx = (CW'(idx_reg) + 1'b1 == count_reg) ? '0 : IW'(idx_reg + 1'b1);

    // sub_reg in S_EPREP: 0 read i, 1 capture i, 2 read j, 3 capture j-i
    always_comb
    begin
        rd_addr = idx_reg;
        if (state_reg == S_EPREP && sub_reg >= 3'd2)
            rd_addr = nxt_idx;
        if (state_reg == S_PLANE)
            rd_addr = IW'(2);
        if (state_reg == S_CDIV)
            rd_addr = IW'(k_reg);
    end

    logic last_in;
    assign last_in = in_fire && in_data.face_end;

    // count after the current beat, and whether the face closes short
    logic [CW-1:0] count_inc;
    logic          short_face;
    assign count_inc  = (count_reg < CW'(MAX_VERTICES)) ? count_reg + 1'b1 : count_reg;
    assign short_face = (count_inc < CW'(3));

    logic out_load;
    assign out_load = (state_reg == S_EOUT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            pn_valid_reg  <= 1'b0;
            sub_reg       <= '0;
            k_reg         <= '0;
            idx_reg       <= '0;
            for (int k = 0; k < 3; k++)
                sum_reg[k] <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (last_in && short_face)
                        begin
                            count_reg <= '0;
                            for (int k = 0; k < 3; k++)
                                sum_reg[k] <= '0;
                        end
                        else if (count_reg < CW'(MAX_VERTICES))
                        begin
                            count_reg <= count_reg + 1'b1;
                            sum_reg[0] <= sum_reg[0] + (36+IW)'(in_data.vertex_x);
                            sum_reg[1] <= sum_reg[1] + (36+IW)'(in_data.vertex_y);
                            sum_reg[2] <= sum_reg[2] + (36+IW)'(in_data.vertex_z);
                        end
                        if (last_in)
                        begin
                            k_reg <= '0;
                            started_reg <= 1'b0;
                            sub_reg <= '0;
                            if (!short_face)
                                state_reg <= S_CDIV;
                        end
                    end
                end
                S_CDIV:
                begin
                    if (udone)
                    begin
                        cen_reg[k_reg] <= 32'(ures);
                        started_reg <= 1'b0;
                        if (k_reg == 2'd2)
                        begin
                            k_reg <= '0;
                            sub_reg <= '0;
                            idx_reg <= '0;
                            state_reg <= S_EPREP;
                        end
                        else
                            k_reg <= k_reg + 2'd1;
                    end
                    else
                        started_reg <= 1'b1;
                end
                S_EPREP:
                begin
                    // idx 0 with plane not built: load v0,v1 then v2
                    if (sub_reg == 3'd1)
                    begin
                        vi_reg[0] <= rdx; vi_reg[1] <= rdy; vi_reg[2] <= rdz;
                    end
                    if (sub_reg == 3'd3)
                    begin
                        ea_reg[0] <= 33'(rdx) - 33'(vi_reg[0]);
                        ea_reg[1] <= 33'(rdy) - 33'(vi_reg[1]);
                        ea_reg[2] <= 33'(rdz) - 33'(vi_reg[2]);
                        sub_reg <= '0;
                        k_reg <= '0;
                        if (pn_valid_reg)
                            state_reg <= S_ECRS;
                        else
                        begin
                            // fetch v2 for plane edge
                            state_reg <= S_PLANE;
                        end
                    end
                    else
                        sub_reg <= sub_reg + 3'd1;
                end
                S_PLANE:
                begin
                    // 0,1: read v2; 2: capture; 3: scale both edges below 2^31; 4,5: cross product
                    case (sub_reg)
                        3'd0:
                        begin
                            sub_reg <= 3'd1;
                        end
                        3'd1:
                        begin
                            sub_reg <= 3'd2;
                        end
                        3'd2:
                        begin
                            eb_reg[0] <= 33'(rdx) - 33'(vi_reg[0]);
                            eb_reg[1] <= 33'(rdy) - 33'(vi_reg[1]);
                            eb_reg[2] <= 33'(rdz) - 33'(vi_reg[2]);
                            sub_reg <= 3'd3;
                        end
                        3'd3:
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                ea_reg[k] <= halve33(ea_reg[k], ea_big);
                                eb_reg[k] <= halve33(eb_reg[k], eb_big);
                            end
                            sub_reg <= 3'd4;
                        end
                        3'd4:
                        begin
                            vec_reg[k_reg] <= 64'(mul_p);
                            sub_reg <= 3'd5;
                        end
                        3'd5:
                        begin
                            vec_reg[k_reg] <= vec_reg[k_reg] - 64'(mul_p);
                            if (k_reg == 2'd2)
                            begin
                                k_reg <= '0;
                                sub_reg <= '0;
                                state_reg <= S_PSQRT;
                            end
                            else
                            begin
                                k_reg <= k_reg + 2'd1;
                                sub_reg <= 3'd4;
                            end
                        end
                        default:
                            sub_reg <= '0;
                    endcase
                end
                S_PSQRT, S_ESQRT:
                begin
                    // sub 0: reduce; 1..3: sum squares; 4: sqrt
                    if (sub_reg == 3'd0)
                    begin
                        for (int k = 0; k < 3; k++)
                            red_reg[k] <= shr_mag(vec_reg[k], rsh);
                        acc_reg <= '0;
                        k_reg <= '0;
                        sub_reg <= 3'd1;
                    end
                    else if (sub_reg <= 3'd3)
                    begin
                        acc_reg <= acc_reg + 64'(mul_p);
                        k_reg <= (sub_reg == 3'd3) ? 2'd0 : k_reg + 2'd1;
                        sub_reg <= sub_reg + 3'd1;
                    end
                    else if (!started_reg)
                    begin
                        started_reg <= 1'b1;
                    end
                    else if (udone)
                    begin
                        len_reg <= 32'(ures);
                        started_reg <= 1'b0;
                        k_reg <= '0;
                        sub_reg <= '0;
                        state_reg <= (state_reg == S_PSQRT) ? S_PDIV : S_EDIV;
                    end
                end
                S_PDIV, S_EDIV:
                begin
                    if (len_reg == 0)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            if (state_reg == S_PDIV) pn_reg[k] <= '0;
                            else un_reg[k] <= '0;
                        end
                        k_reg <= '0;
                        dot_reg <= '0;
                        state_reg <= (state_reg == S_PDIV) ? S_EPREP : S_EDOT;
                        if (state_reg == S_PDIV) pn_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        if (udone)
                        begin
                            started_reg <= 1'b0;
                            if (state_reg == S_PDIV) pn_reg[k_reg] <= 16'(ures);
                            else un_reg[k_reg] <= 16'(ures);
                            if (k_reg == 2'd2)
                            begin
                                k_reg <= '0;
                                dot_reg <= '0;
                                if (state_reg == S_PDIV)
                                begin
                                    pn_valid_reg <= 1'b1;
                                    state_reg <= S_EPREP;
                                end
                                else
                                    state_reg <= S_EDOT;
                            end
                            else
                                k_reg <= k_reg + 2'd1;
                        end
                        else
                            started_reg <= 1'b1;
                    end
                end
                S_ECRS:
                begin
                    if (sub_reg == 3'd0)
                    begin
                        vec_reg[k_reg] <= 64'(mul_p);
                        sub_reg <= 3'd1;
                    end
                    else
                    begin
                        vec_reg[k_reg] <= vec_reg[k_reg] - 64'(mul_p);
                        sub_reg <= 3'd0;
                        if (k_reg == 2'd2)
                        begin
                            k_reg <= '0;
                            state_reg <= S_ESQRT;
                        end
                        else
                            k_reg <= k_reg + 2'd1;
                    end
                end
                S_EDOT:
                begin
                    dot_reg <= dot_reg + 80'(mul_p);
                    if (k_reg == 2'd2)
                    begin
                        k_reg <= '0;
                        state_reg <= S_EOUT;
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                end
                S_EOUT:
                begin
                    if (out_load)
                    begin
                        if (CW'(idx_reg) + 1'b1 == count_reg)
                        begin
                            state_reg <= S_LOAD;
                            count_reg <= '0;
                            pn_valid_reg <= 1'b0;
                            for (int k = 0; k < 3; k++)
                                sum_reg[k] <= '0;
                        end
                        else
                        begin
                            idx_reg <= IW'(idx_reg + 1'b1);
                            sub_reg <= '0;
                            state_reg <= S_EPREP;
                        end
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.edge_index <= 4'(idx_reg);
            out_reg.flipped    <= !dot_reg[79];
            out_reg.edge_nx    <= dot_reg[79] ? un_reg[0] : 16'(-un_reg[0]);
            out_reg.edge_ny    <= dot_reg[79] ? un_reg[1] : 16'(-un_reg[1]);
            out_reg.edge_nz    <= dot_reg[79] ? un_reg[2] : 16'(-un_reg[2]);
            out_reg.plane_nx   <= pn_reg[0];
            out_reg.plane_ny   <= pn_reg[1];
            out_reg.plane_nz   <= pn_reg[2];
            out_reg.centroid_x <= cen_reg[0];
            out_reg.centroid_y <= cen_reg[1];
            out_reg.centroid_z <= cen_reg[2];
            out_reg.last_edge  <= (CW'(idx_reg) + 1'b1 == count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> !in_ready) else $error("ready while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VERTICES)) else $error("vertex count overflow");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("result beat changed while stalled");

endmodule

/* test/tb_polygon_edge_normal_builder_core.sv */
// ----------------------------------------------------------------------------
// tb_polygon_edge_normal_builder_core: self-checking bench for the face edge
// normal builder. Faces of vertices are streamed in with random bursts and
// gaps; a behavioral predictor computes centroid, plane normal and outward
// edge normals per closed face, and every result beat is compared field by
// field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_polygon_edge_normal_builder_core;
    import pen_pkg::*;

    localparam int MAX_VERTS = 16;
    localparam int IDLE_LIMIT = 20000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    pen_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    pen_out_t out_data;

    polygon_edge_normal_builder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    pen_in_t  vertex_queue[$];
    pen_out_t edge_expect_q[$];

    // predictor state
    longint face_pts[MAX_VERTS][3];
    int     face_cnt;
    longint face_sum[3];

    int  errors;
    int  beats_in;
    int  beats_out;
    int  faces_closed;
    int  idle_cycles;
    bit  stim_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void shrink_vec(inout longint v[3], input int bits);
        longint m[3];
        longint lim;
        lim = longint'(1) <<< bits;
        for (int k = 0; k < 3; k++) m[k] = mag(v[k]);
        while (m[0] >= lim || m[1] >= lim || m[2] >= lim)
            for (int k = 0; k < 3; k++) m[k] = m[k] >>> 1;
        for (int k = 0; k < 3; k++) v[k] = (v[k] < 0) ? -m[k] : m[k];
    endfunction

    function automatic void cross_vec(input longint a[3], input longint b[3],
                                      output longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic void unit_vec(input longint v[3], output longint u[3]);
        longint t[3];
        longint unsigned ss;
        longint len;
        t = v;
        shrink_vec(t, 30);
        ss = 0;
        for (int k = 0; k < 3; k++) ss += longint'(t[k] * t[k]);
        len = int_sqrt(ss);
        for (int k = 0; k < 3; k++)
            u[k] = (len == 0) ? 0 : (t[k] * UNIT_ONE) / len;
    endfunction

    // advance the face model by one accepted vertex
    task automatic predict_vertex(input pen_in_t v);
        longint cen[3], e1[3], e2[3], c[3], pn[3];
        longint e[3], raw[3], u[3], d[3], dot;
        int n, j;
        pen_out_t r;
        if (face_cnt < MAX_VERTS)
        begin
            face_pts[face_cnt][0] = longint'(v.vertex_x);
            face_pts[face_cnt][1] = longint'(v.vertex_y);
            face_pts[face_cnt][2] = longint'(v.vertex_z);
            for (int k = 0; k < 3; k++) face_sum[k] += face_pts[face_cnt][k];
            face_cnt++;
        end
        if (!v.face_end) return;
        n = face_cnt;
        for (int k = 0; k < 3; k++)
        begin
            cen[k] = (n != 0) ? face_sum[k] / n : 0;
            face_sum[k] = 0;
        end
        face_cnt = 0;
        faces_closed++;
        if (n < 3) return;
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = face_pts[1][k] - face_pts[0][k];
            e2[k] = face_pts[2][k] - face_pts[0][k];
        end
        shrink_vec(e1, 31);
        shrink_vec(e2, 31);
        cross_vec(e1, e2, c);
        unit_vec(c, pn);
        for (int i = 0; i < n; i++)
        begin
            j = (i + 1 == n) ? 0 : i + 1;
            for (int k = 0; k < 3; k++)
            begin
                e[k] = face_pts[j][k] - face_pts[i][k];
                d[k] = cen[k] - face_pts[i][k];
            end
            shrink_vec(e, 47);
            shrink_vec(d, 47);
            cross_vec(pn, e, raw);
            unit_vec(raw, u);
            dot = u[0] * d[0] + u[1] * d[1] + u[2] * d[2];
            r.flipped = (dot >= 0);
            if (r.flipped)
                for (int k = 0; k < 3; k++) u[k] = -u[k];
            r.edge_index = i[3:0];
            r.edge_nx    = u[0][15:0];
            r.edge_ny    = u[1][15:0];
            r.edge_nz    = u[2][15:0];
            r.plane_nx   = pn[0][15:0];
            r.plane_ny   = pn[1][15:0];
            r.plane_nz   = pn[2][15:0];
            r.centroid_x = cen[0][31:0];
            r.centroid_y = cen[1][31:0];
            r.centroid_z = cen[2][31:0];
            r.last_edge  = (i + 1 == n);
            edge_expect_q = {edge_expect_q, r};
        end
    endtask

    function automatic pen_in_t mk_vtx(int x, int y, int z, bit last);
        pen_in_t v;
        v.vertex_x = x;
        v.vertex_y = y;
        v.vertex_z = z;
        v.face_end = last;
        return v;
    endfunction

    function automatic void put_vtx(pen_in_t v);
        vertex_queue = {vertex_queue, v};
    endfunction

    function automatic int rnd_coord(int mode);
        case (mode)
            0: return $signed($urandom);
            1: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
            default: return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // stimulus
    initial
    begin
        int n, mode, total;
        // directed: triangle, quad with extremes, degenerate, short faces, overfull face
        put_vtx(mk_vtx(0, 0, 0, 0));
        put_vtx(mk_vtx(1 << 16, 0, 0, 0));
        put_vtx(mk_vtx(0, 1 << 16, 0, 1));
        put_vtx(mk_vtx(32'h7fffffff, 32'h7fffffff, 0, 0));
        put_vtx(mk_vtx(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0));
        put_vtx(mk_vtx(32'h80000000, 32'h80000000, 32'h80000000, 0));
        put_vtx(mk_vtx(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1));
        // coincident points: zero-length normals
        put_vtx(mk_vtx(5, 5, 5, 0));
        put_vtx(mk_vtx(5, 5, 5, 0));
        put_vtx(mk_vtx(5, 5, 5, 1));
        // short faces of one and two vertices
        put_vtx(mk_vtx(-1, -1, -1, 1));
        put_vtx(mk_vtx(3, 4, 5, 0));
        put_vtx(mk_vtx(6, 7, 8, 1));
        // overfull face: 18 beats, the last two dropped, close on a dropped one
        for (int i = 0; i < 18; i++)
            put_vtx(mk_vtx(i * 1000, (i * i) * 77, -i * 3, i == 17));

        total = 0;
        while (total < 70)
        begin
            mode = $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0: n = $urandom_range(1, 2);
                1: n = $urandom_range(15, 18);
                default: n = $urandom_range(3, 6);
            endcase
            for (int i = 0; i < n; i++)
                put_vtx(mk_vtx(rnd_coord(mode), rnd_coord(mode),
                               rnd_coord(mode), i == n - 1));
            total += n;
        end
        stim_done = 1'b1;
    end

    // driver: bursts with random gaps
    int gap_left;
    int burst_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            gap_left   <= 0;
            burst_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                predict_vertex(in_data);
                beats_in++;
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (vertex_queue.size() != 0)
            begin
                in_data  <= vertex_queue.pop_front();
                in_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and receiver stall pattern
    logic [7:0] stall_lfsr;
    always @(posedge clk or negedge rst_n)
    begin
        pen_out_t exp_r;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_lfsr <= 8'h5a;
        end
        else
        begin
            stall_lfsr <= 8'($urandom);
            // ready drawn at random each cycle: mostly high, with occasional stalls
            out_ready  <= stall_lfsr[7] ? 1'b1 : (stall_lfsr[1:0] != 2'b00);
            if (out_valid && out_ready)
            begin
                beats_out++;
                if (edge_expect_q.size() == 0)
                begin
                    $error("unexpected result beat edge_index=%0d", out_data.edge_index);
                    errors++;
                end
                else
                begin
                    exp_r = edge_expect_q.pop_front();
                    if (out_data.edge_index !== exp_r.edge_index)
                    begin
                        $error("edge_index exp %0d got %0d", exp_r.edge_index,
                               out_data.edge_index);
                        errors++;
                    end
                    if (out_data.edge_nx !== exp_r.edge_nx)
                    begin
                        $error("edge_nx exp %0d got %0d", exp_r.edge_nx, out_data.edge_nx);
                        errors++;
                    end
                    if (out_data.edge_ny !== exp_r.edge_ny)
                    begin
                        $error("edge_ny exp %0d got %0d", exp_r.edge_ny, out_data.edge_ny);
                        errors++;
                    end
                    if (out_data.edge_nz !== exp_r.edge_nz)
                    begin
                        $error("edge_nz exp %0d got %0d", exp_r.edge_nz, out_data.edge_nz);
                        errors++;
                    end
                    if (out_data.flipped !== exp_r.flipped)
                    begin
                        $error("flipped exp %0d got %0d", exp_r.flipped, out_data.flipped);
                        errors++;
                    end
                    if (out_data.plane_nx !== exp_r.plane_nx)
                    begin
                        $error("plane_nx exp %0d got %0d", exp_r.plane_nx, out_data.plane_nx);
                        errors++;
                    end
                    if (out_data.plane_ny !== exp_r.plane_ny)
                    begin
                        $error("plane_ny exp %0d got %0d", exp_r.plane_ny, out_data.plane_ny);
                        errors++;
                    end
                    if (out_data.plane_nz !== exp_r.plane_nz)
                    begin
                        $error("plane_nz exp %0d got %0d", exp_r.plane_nz, out_data.plane_nz);
                        errors++;
                    end
                    if (out_data.centroid_x !== exp_r.centroid_x)
                    begin
                        $error("centroid_x exp %0d got %0d", exp_r.centroid_x,
                               out_data.centroid_x);
                        errors++;
                    end
                    if (out_data.centroid_y !== exp_r.centroid_y)
                    begin
                        $error("centroid_y exp %0d got %0d", exp_r.centroid_y,
                               out_data.centroid_y);
                        errors++;
                    end
                    if (out_data.centroid_z !== exp_r.centroid_z)
                    begin
                        $error("centroid_z exp %0d got %0d", exp_r.centroid_z,
                               out_data.centroid_z);
                        errors++;
                    end
                    if (out_data.last_edge !== exp_r.last_edge)
                    begin
                        $error("last_edge exp %0d got %0d", exp_r.last_edge,
                               out_data.last_edge);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog: cycles without any accepted beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // reset and end of run
    initial
    begin
        errors       = 0;
        beats_in     = 0;
        beats_out    = 0;
        faces_closed = 0;
        idle_cycles  = 0;
        face_cnt     = 0;
        for (int k = 0; k < 3; k++) face_sum[k] = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        while (vertex_queue.size() != 0 || in_valid || edge_expect_q.size() != 0)
            @(posedge clk);
        // any stray beat from a short face would show up within this window
        repeat (6000) @(posedge clk);
        $display("covered %0d vertex beats in %0d faces, %0d edge results checked",
                 beats_in, faces_closed, beats_out);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
src/pen_pkg.sv
src/pen_divsqrt.sv
src/polygon_edge_normal_builder_core.sv
test/tb_polygon_edge_normal_builder_core.sv
